[hdl/qcv_pkg.sv]
// ----------------------------------------------------------------------------
// qcv_pkg
// Shared types and constants of the quadrature count and velocity block.
// ----------------------------------------------------------------------------
package qcv_pkg;

    localparam int unsigned COUNT_W   = 32;
    localparam int unsigned TIME_W    = 32;
    localparam int unsigned VEL_W     = 29;
    localparam int unsigned SCALE_W   = 28;
    localparam int unsigned DIV_CNT_W = $clog2(SCALE_W);

    // 1e6 edges per second in Q8, the dividend of every velocity divide.
    localparam logic [SCALE_W-1:0] VEL_SCALE   = 28'd256000000;
    localparam logic [TIME_W-1:0]  TIMEOUT_RST = 32'd100000;

    localparam int unsigned IN_TDATA_W  = 40;
    localparam int unsigned OUT_TDATA_W = 64;

    typedef enum logic [1:0] {
        OP_PIN   = 2'd0,
        OP_TICK  = 2'd1,
        OP_CLEAR = 2'd2
    } t_opcode;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic elapsed_en;
        logic div_start;
        logic div_step;
        logic commit;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic need_div;
        logic div_last;
        logic out_free;
    } t_status;

endpackage

[hdl/qcv_ctrl.sv]
// ----------------------------------------------------------------------------
// qcv_ctrl
// Sequencer: accepts a request, steps the datapath through elapsed time,
// the optional divide and the commit into the output register.
// ----------------------------------------------------------------------------
module qcv_ctrl
    import qcv_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_CHECK,
        S_DIV,
        S_COMMIT
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                n_state = S_CHECK;
            end
            S_CHECK: begin
                n_state = i_status.need_div ? S_DIV : S_COMMIT;
            end
            S_DIV: begin
                if (i_status.div_last) begin
                    n_state = S_COMMIT;
                end
            end
            S_COMMIT: begin
                if (i_status.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready       = (r_state == S_IDLE);
    assign o_cmd.load       = (r_state == S_IDLE) && i_in_valid;
    assign o_cmd.elapsed_en = (r_state == S_EVAL);
    assign o_cmd.div_start  = (r_state == S_CHECK);
    assign o_cmd.div_step   = (r_state == S_DIV);
    assign o_cmd.commit     = (r_state == S_COMMIT) && i_status.out_free;

endmodule

[hdl/qcv_dpath.sv]
// ----------------------------------------------------------------------------
// qcv_dpath
// Datapath: request registers, count and velocity state, a radix-2
// restoring divider and the output register.
// ----------------------------------------------------------------------------
module qcv_dpath
    import qcv_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_cmd                    i_cmd,
    output t_status                 o_status,
    input  logic [IN_TDATA_W-1:0]   i_in_data,
    input  logic [1:0]              i_in_user,
    input  logic                    i_cfg_we,
    input  logic [TIME_W-1:0]       i_cfg_wdata,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic [OUT_TDATA_W-1:0]  o_out_data
);

    // Request
    t_opcode            r_op;
    logic               r_a;
    logic               r_b;
    logic [TIME_W-1:0]  r_now;
    logic [TIME_W-1:0]  r_elapsed;

    // Block state
    logic [TIME_W-1:0]  r_timeout;
    logic               r_last_a;
    logic [COUNT_W-1:0] r_count;
    logic [VEL_W-1:0]   r_vel;
    logic [TIME_W-1:0]  r_last_edge;

    // Divider
    logic [TIME_W-1:0]    r_rem;
    logic [SCALE_W-1:0]   r_dvd;
    logic [SCALE_W-1:0]   r_quo;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [TIME_W:0]      rem_shift;
    logic                 rem_ge;

    // Output register
    logic                 r_out_valid;
    logic [COUNT_W-1:0]   r_out_count;
    logic [VEL_W-1:0]     r_out_vel;

    logic [COUNT_W-1:0]   n_count;
    logic [VEL_W-1:0]     n_vel;
    logic [TIME_W-1:0]    n_last_edge;
    logic                 n_last_a;
    logic                 a_edge;
    logic                 step_up;

    assign a_edge  = (r_a != r_last_a);
    assign step_up = (r_b != r_a);

    assign o_status.need_div = (r_op == OP_PIN) && a_edge && (r_elapsed != '0);
    assign o_status.div_last = (r_cnt == '0);
    assign o_status.out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= TIMEOUT_RST;
        end else if (i_cfg_we) begin
            r_timeout <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= t_opcode'(i_in_user);
            r_a   <= i_in_data[0];
            r_b   <= i_in_data[1];
            r_now <= i_in_data[TIME_W+1:2];
        end
        if (i_cmd.elapsed_en) begin
            r_elapsed <= r_now - r_last_edge;
        end
    end

    // One quotient bit per cycle; the remainder always stays below the divisor.
    assign rem_shift = {r_rem, r_dvd[SCALE_W-1]};
    assign rem_ge    = (rem_shift >= {1'b0, r_elapsed});

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_rem <= '0;
            r_dvd <= VEL_SCALE;
            r_quo <= '0;
            r_cnt <= DIV_CNT_W'(SCALE_W - 1);
        end else if (i_cmd.div_step) begin
            r_rem <= rem_ge ? TIME_W'(rem_shift - {1'b0, r_elapsed}) : rem_shift[TIME_W-1:0];
            r_dvd <= {r_dvd[SCALE_W-2:0], 1'b0};
            r_quo <= {r_quo[SCALE_W-2:0], rem_ge};
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_comb begin
        n_count     = r_count;
        n_vel       = r_vel;
        n_last_edge = r_last_edge;
        n_last_a    = r_last_a;
        case (r_op)
            OP_PIN: begin
                if (a_edge) begin
                    n_count     = step_up ? r_count + 1'b1 : r_count - 1'b1;
                    n_last_edge = r_now;
                    if (r_elapsed != '0) begin
                        n_vel = step_up ? VEL_W'(r_quo) : VEL_W'(0) - VEL_W'(r_quo);
                    end
                end
                n_last_a = r_a;
            end
            OP_TICK: begin
                if (r_elapsed > r_timeout) begin
                    n_vel = '0;
                end
            end
            OP_CLEAR: begin
                n_count = '0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_a    <= 1'b0;
            r_count     <= '0;
            r_vel       <= '0;
            r_last_edge <= '0;
        end else if (i_cmd.commit) begin
            r_last_a    <= n_last_a;
            r_count     <= n_count;
            r_vel       <= n_vel;
            r_last_edge <= n_last_edge;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out_count <= n_count;
            r_out_vel   <= n_vel;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = {(OUT_TDATA_W - COUNT_W - VEL_W)'(0), r_out_vel, r_out_count};

`ifndef SYNTHESIS
    a_commit_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |-> (!r_out_valid || i_out_ready))
        else $error("Result committed over an untaken result.");

    a_commit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |=> r_out_valid)
        else $error("Committed result not presented.");

    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_step |-> (r_rem < r_elapsed))
        else $error("Divider remainder not below divisor.");

    a_div_needs_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_step |-> (r_elapsed != '0))
        else $error("Divide started with zero elapsed time.");
`endif

endmodule

[hdl/quadrature_count_and_velocity.sv]
// ----------------------------------------------------------------------------
// quadrature_count_and_velocity
// x2 quadrature decoder on channel A with position count and Q8 velocity
// from the time between counted edges.
//
//   Channel   Direction  Payload
//   s_axis    in         tuser = opcode; tdata = pin_a, pin_b, now_us
//   m_axis    out        tdata = position_count, velocity_q8
//   cfg       in         i_cfg_wdata = timeout_us, written on i_cfg_we
//
// A request that changes channel A after nonzero elapsed time passes through
// the accept state, a state for the elapsed time, a state for the check, the
// radix-2 divide of 256000000 by the elapsed time into a 28-bit quotient, and
// the commit. Every other request skips the divide. Requests are taken one at
// a time. A result waits in the output register while the next request is
// worked on; only the commit waits for m_axis_tready.
// Reset is synchronous, no clear pass.
// ----------------------------------------------------------------------------
module quadrature_count_and_velocity
    import qcv_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // pin_a, pin_b, now_us[31:0]
    input  logic [1:0]             s_axis_tuser,   // opcode
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // position_count, velocity_q8
    input  logic                   i_cfg_we,
    input  logic [TIME_W-1:0]      i_cfg_wdata
);

    t_cmd    cmd;
    t_status status;

    qcv_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    qcv_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_in_data   (s_axis_tdata),
        .i_in_user   (s_axis_tuser),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_data  (m_axis_tdata)
    );

endmodule

[tb/tb_quadrature_count_and_velocity.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_quadrature_count_and_velocity
// Drives pin samples, timeout ticks and count clears into the decoder, and
// checks each result's count and velocity against typed rows or a bench model.
// A short table covers reset values, edge cases and extremes. Random encoder
// motion with noise follows, under several timeout settings and idle mixes.
// ----------------------------------------------------------------------------
module tb_quadrature_count_and_velocity;
    import qcv_pkg::*;

    localparam logic [1:0]  OP_UNUSED   = 2'd3;
    localparam int          ITEMS_PHASE = 420;
    localparam logic [31:0] SCALE_32    = {{(32-SCALE_W){1'b0}}, VEL_SCALE};

    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic [VEL_W-1:0]   vel;
    } t_motion;

    typedef struct packed {
        logic [1:0]        op;
        logic              pin_a;
        logic              pin_b;
        logic [TIME_W-1:0] now;
        logic              typed;
        t_motion           want;
    } t_stim_row;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;   // pin_a, pin_b, now_us[31:0]
    logic [1:0]             s_axis_tuser;   // opcode
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;   // position_count, velocity_q8
    logic                   i_cfg_we;
    logic [TIME_W-1:0]      i_cfg_wdata;

    // Model state of the decoder.
    logic              enc_last_a;
    logic [31:0]       enc_count;
    logic [31:0]       enc_vel;
    logic [TIME_W-1:0] enc_edge_time;
    logic [TIME_W-1:0] enc_timeout;

    t_motion expected_motion_q[$];
    int      mismatch_count;
    int      tx_idle_pct;
    int      rx_idle_pct;

    quadrature_count_and_velocity dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

    function automatic t_motion predict_motion(input logic [1:0] op, input logic a,
                                               input logic b, input logic [31:0] now);
        logic [31:0] elapsed;
        logic [31:0] mag;
        logic        up;
        t_motion     res;
        elapsed = now - enc_edge_time;
        if (op == OP_PIN) begin
            if (a != enc_last_a) begin
                up = (b != a);
                enc_count = up ? enc_count + 32'd1 : enc_count - 32'd1;
                // An edge at the same timestamp keeps the old velocity.
                if (elapsed != 32'd0) begin
                    mag = SCALE_32 / elapsed;
                    enc_vel = up ? mag : 32'd0 - mag;
                end
                enc_edge_time = now;
            end
            enc_last_a = a;
        end else if (op == OP_TICK) begin
            if (elapsed > enc_timeout) begin
                enc_vel = 32'd0;
            end
        end else if (op == OP_CLEAR) begin
            enc_count = 32'd0;
        end
        res.count = enc_count;
        res.vel   = enc_vel[VEL_W-1:0];
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t ns: %s mismatch, got %h expected %h", $time, what, got, want);
        mismatch_count++;
    endtask

    task automatic send_request(input logic [1:0] op, input logic a, input logic b,
                                input logic [31:0] now, input logic typed,
                                input t_motion want);
        t_motion pred;
        @(negedge i_clk);
        while (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {{(IN_TDATA_W-34){1'b0}}, now, b, a};
        do @(posedge i_clk); while (!s_axis_tready);
        pred = predict_motion(op, a, b, now);
        expected_motion_q.push_back(typed ? want : pred);
    endtask

    // Holds the sender off until every outstanding request has its result.
    task automatic drain_results();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (expected_motion_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_timeout(input logic [31:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        enc_timeout = value;
    endtask

    always @(negedge i_clk) begin
        m_axis_tready <= i_rst_n &&
                         ((rx_idle_pct == 0) || ($urandom_range(0, 99) >= rx_idle_pct));
    end

    always @(posedge i_clk) begin
        t_motion want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_motion_q.size() == 0) begin
                report_mismatch("unrequested result", m_axis_tdata[31:0], 32'd0);
            end else begin
                want = expected_motion_q.pop_front();
                if (m_axis_tdata[31:0] !== want.count) begin
                    report_mismatch("position_count", m_axis_tdata[31:0], want.count);
                end
                if (m_axis_tdata[32 +: VEL_W] !== want.vel) begin
                    report_mismatch("velocity_q8", {3'b0, m_axis_tdata[32 +: VEL_W]},
                                    {3'b0, want.vel});
                end
            end
        end
    end

    initial begin
        t_stim_row   dir_rows [15];
        t_motion     none;
        logic [31:0] now;
        logic [31:0] delta;
        logic [1:0]  op;
        logic        pa;
        logic        pb;
        int          q_idx;
        int          q_dir;
        int          r;

        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = OP_PIN;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = '0;
        mismatch_count = 0;
        tx_idle_pct   = 37;
        rx_idle_pct   = 69;
        enc_last_a    = 1'b0;
        enc_count     = 32'd0;
        enc_vel       = 32'd0;
        enc_edge_time = '0;
        enc_timeout   = TIMEOUT_RST;
        none          = '0;

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset values, unchanged A, an edge at zero elapsed time, the full-scale
        // velocities of both signs, timestamp wrap, the timeout boundary, clears
        // with count wrap below zero, and the unused opcode.
        dir_rows[0]  = '{OP_TICK,   1'b1, 1'b1, 32'd0,        1'b1, '{32'd0, 29'd0}};
        dir_rows[1]  = '{OP_PIN,    1'b0, 1'b0, 32'd5,        1'b1, '{32'd0, 29'd0}};
        dir_rows[2]  = '{OP_PIN,    1'b1, 1'b0, 32'd0,        1'b1, '{32'd1, 29'd0}};
        dir_rows[3]  = '{OP_PIN,    1'b0, 1'b0, 32'd1,        1'b1,
                         '{32'd0, -29'sd256000000}};
        dir_rows[4]  = '{OP_PIN,    1'b1, 1'b0, 32'd2,        1'b1,
                         '{32'd1, 29'd256000000}};
        dir_rows[5]  = '{OP_PIN,    1'b0, 1'b1, 32'hFFFF_FFFF, 1'b0, none};
        dir_rows[6]  = '{OP_PIN,    1'b1, 1'b1, 32'd3,        1'b0, none};
        dir_rows[7]  = '{OP_TICK,   1'b0, 1'b0, 32'd100003,   1'b0, none};
        dir_rows[8]  = '{OP_TICK,   1'b1, 1'b0, 32'd100004,   1'b0, none};
        dir_rows[9]  = '{OP_PIN,    1'b0, 1'b0, 32'd100010,   1'b0, none};
        dir_rows[10] = '{OP_PIN,    1'b1, 1'b0, 32'd100500,   1'b0, none};
        dir_rows[11] = '{OP_CLEAR,  1'b0, 1'b1, 32'd100550,   1'b0, none};
        dir_rows[12] = '{OP_PIN,    1'b0, 1'b0, 32'd100600,   1'b0, none};
        dir_rows[13] = '{OP_UNUSED, 1'b1, 1'b1, 32'hFFFF_FFFF, 1'b0, none};
        dir_rows[14] = '{OP_PIN,    1'b1, 1'b1, 32'd100600,   1'b0, none};

        foreach (dir_rows[i]) begin
            send_request(dir_rows[i].op, dir_rows[i].pin_a, dir_rows[i].pin_b,
                         dir_rows[i].now, dir_rows[i].typed, dir_rows[i].want);
        end

        now   = 32'd100600;
        q_idx = 2;
        q_dir = 1;
        for (int phase = 0; phase < 4; phase++) begin
            drain_results();
            case (phase)
                0: write_timeout(32'd500);
                1: write_timeout(32'd0);
                2: write_timeout(32'hFFFF_FFFF);
                default: write_timeout($urandom_range(50, 5000));
            endcase
            tx_idle_pct = (phase == 0) ? 37 : (phase == 1) ? 69 : 0;
            rx_idle_pct = (phase == 0) ? 69 : (phase == 1) ? 37 : 0;

            repeat (ITEMS_PHASE) begin
                r = $urandom_range(0, 99);
                if (r < 6) begin
                    delta = 32'd0;
                end else if (r < 66) begin
                    delta = $urandom_range(1, 400);
                end else if (r < 81) begin
                    delta = $urandom_range(401, 5000);
                end else if (r < 91) begin
                    delta = $urandom_range(90000, 200000);
                end else if (r < 96) begin
                    delta = $urandom;
                end else begin
                    delta = 32'd1;
                end
                now = now + delta;

                r = $urandom_range(0, 99);
                if (r < 70) begin
                    // A Gray-code step of the encoder, mostly in one direction.
                    if ($urandom_range(0, 99) < 15) q_dir = -q_dir;
                    q_idx = (q_idx + q_dir + 4) % 4;
                    op = OP_PIN;
                    pa = (q_idx == 1 || q_idx == 2);
                    pb = (q_idx == 2 || q_idx == 3);
                end else begin
                    pa = 1'($urandom_range(0, 1));
                    pb = 1'($urandom_range(0, 1));
                    if (r < 85) begin
                        op = OP_TICK;
                    end else if (r < 90) begin
                        op = OP_CLEAR;
                    end else if (r < 93) begin
                        op = OP_UNUSED;
                    end else begin
                        // A glitch on the pins; the walk resumes from where it lands.
                        op = OP_PIN;
                        q_idx = pa ? (pb ? 2 : 1) : (pb ? 3 : 0);
                    end
                end
                send_request(op, pa, pb, now, 1'b0, none);
            end
        end

        drain_results();
        repeat (40) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

[quadrature_count_and_velocity.f]
hdl/qcv_pkg.sv
hdl/qcv_ctrl.sv
hdl/qcv_dpath.sv
hdl/quadrature_count_and_velocity.sv
tb/tb_quadrature_count_and_velocity.sv
